>>> hw/rtl/sbsm_pkg.sv
// Package for the serial bank switch mapper: payload types, action codes,
// register select codes and program banking modes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sbsm_pkg;

  // bus action codes
  localparam logic [1:0] ACT_PRG_READ  = 2'd0;
  localparam logic [1:0] ACT_PRG_WRITE = 2'd1;
  localparam logic [1:0] ACT_PATTERN   = 2'd2;

  // serial port register select, address bits 14:13
  localparam logic [1:0] SEL_CONTROL  = 2'd0;
  localparam logic [1:0] SEL_CHR_LOW  = 2'd1;
  localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
  localparam logic [1:0] SEL_PRG      = 2'd3;

  // program banking modes
  localparam logic [1:0] PRG_SWITCH_32K = 2'd0;
  localparam logic [1:0] PRG_FIX_LOW    = 2'd1;
  localparam logic [1:0] PRG_FIX_HIGH   = 2'd2;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] REG_PRG_BANK_COUNT = 3'd0;
  localparam logic [4:0] PRG_BANK_COUNT_RESET = 5'd2;

  // serial port
  localparam logic [2:0] SERIAL_LAST = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] address;
    logic [7:0]  write_data;
  } sbsm_req_t;

  typedef struct packed {
    logic [17:0] mapped_address;
    logic        use_ram;
    logic        in_range;
    logic [1:0]  mirroring;
  } sbsm_rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/sbsm_if.sv
// Valid/ready channel interfaces for the mapper's request and result streams.
// Depends on sbsm_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface sbsm_req_if import sbsm_pkg::*; ();
  logic      valid;
  logic      ready;
  sbsm_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sbsm_rsp_if import sbsm_pkg::*; ();
  logic      valid;
  logic      ready;
  sbsm_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/serial_bank_switch_mapper.sv
// Top level of the serial bank switch mapper: address translation, serial
// register port and configuration port. Depends on sbsm_pkg and sbsm_if.
`timescale 1ns / 1ps
`default_nettype none

// Cartridge bank-switching mapper. Each request (program read, program write
// or pattern access) is translated in the cycle it is accepted, and its result
// sits in an output register from the next cycle on, so one request transfers every
// clock while the result side keeps up; a stalled result only holds back the
// next request. Program writes to 0x8000..0xFFFF shift bit 0 into a five-bit
// serial port (bit 7 set clears it) and the fifth write commits to the
// register chosen by address bits 14:13; the result of a write already shows
// the new mirroring. The bank count register at byte address 0 may be written
// only while no request is in flight.
module serial_bank_switch_mapper
  import sbsm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  sbsm_req_if.sink                   req,
  sbsm_rsp_if.source                 rsp,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  // mapper state
  logic [4:0]  prg_bank_count;
  logic [3:0]  serial_bits, serial_bits_next;
  logic [2:0]  serial_count, serial_count_next;
  logic        ram_enabled, ram_enabled_next;
  logic [1:0]  prg_mode, prg_mode_next;
  logic        chr_mode_4k, chr_mode_4k_next;
  logic [2:0]  prg_bank_32k, prg_bank_32k_next;
  logic [3:0]  prg_bank_16k, prg_bank_16k_next;
  logic [3:0]  chr_bank_8k, chr_bank_8k_next;
  logic [4:0]  chr_bank_low, chr_bank_low_next;
  logic [4:0]  chr_bank_high, chr_bank_high_next;
  logic [1:0]  mirror_mode, mirror_mode_next;

  // output register
  logic        rsp_valid;
  sbsm_rsp_t   rsp_data;

  logic        accept;
  logic [1:0]  action;
  logic [15:0] addr;
  logic [7:0]  wdata;
  logic        ram_hit;
  logic        rom_hit;
  logic        reg_write;
  logic [4:0]  commit_value;
  logic [1:0]  ctrl_mode;
  logic [3:0]  high_bank;
  logic [4:0]  count_less_one;
  logic        low_half;
  logic [17:0] rom_address;
  logic [16:0] chr_address;
  sbsm_rsp_t   result;

  assign accept    = req.valid && req.ready;
  assign req.ready = !rsp_valid || rsp.ready;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  assign action = req.data.action;
  assign addr   = req.data.address;
  assign wdata  = req.data.write_data;

  // configuration port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[APB_ADDR_W-1:2] == REG_PRG_BANK_COUNT[APB_ADDR_W-1:2]) begin
      prdata = {{(APB_DATA_W-5){1'b0}}, prg_bank_count};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count <= PRG_BANK_COUNT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[APB_ADDR_W-1:2] == REG_PRG_BANK_COUNT[APB_ADDR_W-1:2]) begin
      prg_bank_count <= pwdata[4:0];
    end
  end

  // window decode
  assign ram_hit   = ram_enabled && (addr[15:13] == 3'b011);
  assign rom_hit   = addr[15];
  assign reg_write = (action == ACT_PRG_WRITE) && !ram_hit && rom_hit;

  // serial port and register commit
  assign commit_value = {wdata[0], serial_bits};
  assign ctrl_mode    = commit_value[3:2];

  always_comb begin
    serial_bits_next   = serial_bits;
    serial_count_next  = serial_count;
    ram_enabled_next   = ram_enabled;
    prg_mode_next      = prg_mode;
    chr_mode_4k_next   = chr_mode_4k;
    prg_bank_32k_next  = prg_bank_32k;
    prg_bank_16k_next  = prg_bank_16k;
    chr_bank_8k_next   = chr_bank_8k;
    chr_bank_low_next  = chr_bank_low;
    chr_bank_high_next = chr_bank_high;
    mirror_mode_next   = mirror_mode;
    if (reg_write) begin
      if (wdata[7]) begin
        serial_bits_next  = '0;
        serial_count_next = '0;
      end else if (serial_count < SERIAL_LAST) begin
        serial_bits_next  = {wdata[0], serial_bits[3:1]};
        serial_count_next = serial_count + 3'd1;
      end else begin
        serial_bits_next  = '0;
        serial_count_next = '0;
        case (addr[14:13])
          SEL_CONTROL: begin
            mirror_mode_next = commit_value[1:0];
            chr_mode_4k_next = commit_value[4];
            if (ctrl_mode[1] == 1'b0) begin
              prg_mode_next = PRG_SWITCH_32K;
            end else if (ctrl_mode[0] == 1'b0) begin
              prg_mode_next = PRG_FIX_LOW;
            end else begin
              prg_mode_next = PRG_FIX_HIGH;
            end
          end
          SEL_CHR_LOW: begin
            chr_bank_8k_next  = commit_value[4:1];
            chr_bank_low_next = commit_value;
          end
          SEL_CHR_HIGH: begin
            chr_bank_high_next = commit_value;
          end
          default: begin
            prg_bank_32k_next = commit_value[3:1];
            prg_bank_16k_next = commit_value[3:0];
            ram_enabled_next  = !commit_value[4];
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      serial_bits   <= '0;
      serial_count  <= '0;
      ram_enabled   <= 1'b0;
      prg_mode      <= PRG_FIX_HIGH;
      chr_mode_4k   <= 1'b1;
      prg_bank_32k  <= '0;
      prg_bank_16k  <= '0;
      chr_bank_8k   <= '0;
      chr_bank_low  <= '0;
      chr_bank_high <= '0;
      mirror_mode   <= '0;
    end else if (accept) begin
      serial_bits   <= serial_bits_next;
      serial_count  <= serial_count_next;
      ram_enabled   <= ram_enabled_next;
      prg_mode      <= prg_mode_next;
      chr_mode_4k   <= chr_mode_4k_next;
      prg_bank_32k  <= prg_bank_32k_next;
      prg_bank_16k  <= prg_bank_16k_next;
      chr_bank_8k   <= chr_bank_8k_next;
      chr_bank_low  <= chr_bank_low_next;
      chr_bank_high <= chr_bank_high_next;
      mirror_mode   <= mirror_mode_next;
    end
  end

  // program rom translation
  assign count_less_one = prg_bank_count - 5'd1;
  assign high_bank      = (prg_bank_count == 5'd0) ? 4'd0 : count_less_one[3:0];
  assign low_half       = !addr[14];

  always_comb begin
    case (prg_mode)
      PRG_SWITCH_32K: rom_address = {prg_bank_32k, addr[14:0]};
      PRG_FIX_LOW: begin
        rom_address = low_half ? {4'd0, addr[13:0]} : {prg_bank_16k, addr[13:0]};
      end
      default: begin
        rom_address = low_half ? {prg_bank_16k, addr[13:0]} : {high_bank, addr[13:0]};
      end
    endcase
  end

  // pattern translation
  always_comb begin
    if (chr_mode_4k) begin
      chr_address = addr[12] ? {chr_bank_high, addr[11:0]} : {chr_bank_low, addr[11:0]};
    end else begin
      chr_address = {chr_bank_8k, addr[12:0]};
    end
  end

  // result select
  always_comb begin
    result.mapped_address = '0;
    result.use_ram        = 1'b0;
    result.in_range       = 1'b0;
    result.mirroring      = mirror_mode_next;
    case (action)
      ACT_PRG_READ, ACT_PRG_WRITE: begin
        if (ram_hit) begin
          result.mapped_address = {5'd0, addr[12:0]};
          result.use_ram        = 1'b1;
          result.in_range       = 1'b1;
        end else if (rom_hit) begin
          result.in_range = 1'b1;
          if (action == ACT_PRG_READ) begin
            result.mapped_address = rom_address;
          end
        end
      end
      ACT_PATTERN: begin
        if (addr[15:13] == 3'b000) begin
          result.mapped_address = {1'b0, chr_address};
          result.in_range       = 1'b1;
        end
      end
      default: begin
        result.in_range = 1'b0;
      end
    endcase
  end

  // output register, loaded on each request transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_data <= result;
    end
  end

endmodule

`default_nettype wire

>>> sim/serial_bank_switch_mapper_test.sv
// Self-checking testbench for serial_bank_switch_mapper: drives bus accesses and
// bank count writes, predicts every result and compares it field by field.
// Depends on sbsm_pkg, sbsm_if and the mapper top level.
`timescale 1ns / 1ps

module serial_bank_switch_mapper_test
  import sbsm_pkg::*;
();

  // action code the block does not define
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 120;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_TARGET = 330;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  sbsm_req_if req_if ();
  sbsm_rsp_if rsp_if ();

  serial_bank_switch_mapper uut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // mapper state as the predictor sees it
  logic [4:0] bank_count_m;
  logic [3:0] shift_bits_m;
  logic [2:0] shift_count_m;
  logic       ram_on_m;
  logic [1:0] prg_mode_m;
  logic       chr_split_m;
  logic [2:0] bank32_m;
  logic [3:0] bank16_m;
  logic [3:0] chr8k_m;
  logic [4:0] chr_low_m;
  logic [4:0] chr_high_m;
  logic [1:0] mirror_m;

  sbsm_rsp_t pending_translations[$];
  sbsm_rsp_t want;

  int mismatch_count = 0;
  int results_checked = 0;
  int items_sent = 0;
  int commits_seen = 0;
  int count_settings = 0;
  int input_stall_cycles = 0;
  bit src_gaps = 1'b1;
  bit sink_gaps = 1'b1;
  bit hold_results = 1'b0;

  // clock, 2 ns period
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // translate one access and update the register file, as the mapper does
  function automatic sbsm_rsp_t predict_access(input sbsm_req_t r);
    sbsm_rsp_t res;
    logic [15:0] a;
    logic [4:0] v;
    logic [4:0] last_bank;
    logic [3:0] high_bank;
    res = '0;
    a = r.address;
    if (r.action == ACT_PRG_READ || r.action == ACT_PRG_WRITE) begin
      if (ram_on_m && a >= 16'h6000 && a <= 16'h7FFF) begin
        res.mapped_address = {5'd0, a[12:0]};
        res.use_ram = 1'b1;
        res.in_range = 1'b1;
      end else if (a[15]) begin
        res.in_range = 1'b1;
        if (r.action == ACT_PRG_READ) begin
          // program rom window
          case (prg_mode_m)
            PRG_SWITCH_32K: res.mapped_address = {bank32_m, a[14:0]};
            PRG_FIX_LOW: res.mapped_address = a[14] ? {bank16_m, a[13:0]} : {4'd0, a[13:0]};
            default: begin
              last_bank = bank_count_m - 5'd1;
              high_bank = (bank_count_m == 5'd0) ? 4'd0 : last_bank[3:0];
              res.mapped_address = a[14] ? {high_bank, a[13:0]} : {bank16_m, a[13:0]};
            end
          endcase
        end else if (r.write_data[7]) begin
          shift_bits_m = '0;
          shift_count_m = '0;
        end else if (shift_count_m < SERIAL_LAST) begin
          shift_bits_m = {r.write_data[0], shift_bits_m[3:1]};
          shift_count_m = shift_count_m + 3'd1;
        end else begin
          // fifth bit commits to the register picked by address bits 14:13
          v = {r.write_data[0], shift_bits_m};
          shift_bits_m = '0;
          shift_count_m = '0;
          commits_seen++;
          case (a[14:13])
            SEL_CONTROL: begin
              mirror_m = v[1:0];
              prg_mode_m = !v[3] ? PRG_SWITCH_32K : (v[2] ? PRG_FIX_HIGH : PRG_FIX_LOW);
              chr_split_m = v[4];
            end
            SEL_CHR_LOW: begin
              chr8k_m = v[4:1];
              chr_low_m = v;
            end
            SEL_CHR_HIGH: chr_high_m = v;
            default: begin
              bank32_m = v[3:1];
              bank16_m = v[3:0];
              ram_on_m = ~v[4];
            end
          endcase
        end
      end
    end else if (r.action == ACT_PATTERN && a <= 16'h1FFF) begin
      res.in_range = 1'b1;
      if (chr_split_m)
        res.mapped_address = {1'b0, (a[12] ? chr_high_m : chr_low_m), a[11:0]};
      else
        res.mapped_address = {1'b0, chr8k_m, a[12:0]};
    end
    res.mirroring = mirror_m;
    return res;
  endfunction

  task automatic note_mismatch(input string what, input int unsigned got,
                               input int unsigned exp_val);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("mismatch at result %0d, %s: got 0x%0h, expected 0x%0h",
               results_checked, what, got, exp_val);
  endtask

  // record each request transfer, then check each result transfer
  always @(posedge clk) begin
    if (rst) begin
      bank_count_m <= PRG_BANK_COUNT_RESET;
      shift_bits_m <= '0;
      shift_count_m <= '0;
      ram_on_m <= 1'b0;
      prg_mode_m <= PRG_FIX_HIGH;
      chr_split_m <= 1'b1;
      bank32_m <= '0;
      bank16_m <= '0;
      chr8k_m <= '0;
      chr_low_m <= '0;
      chr_high_m <= '0;
      mirror_m <= '0;
    end else begin
      if (req_if.valid && !req_if.ready)
        input_stall_cycles++;
      if (req_if.valid && req_if.ready)
        pending_translations.push_back(predict_access(req_if.data));
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_translations.size() == 0) begin
          note_mismatch("result with nothing expected", 32'(rsp_if.data), 0);
        end else begin
          want = pending_translations.pop_front();
          if (rsp_if.data.mapped_address !== want.mapped_address)
            note_mismatch("mapped_address", 32'(rsp_if.data.mapped_address),
                          32'(want.mapped_address));
          if (rsp_if.data.use_ram !== want.use_ram)
            note_mismatch("use_ram", 32'(rsp_if.data.use_ram), 32'(want.use_ram));
          if (rsp_if.data.in_range !== want.in_range)
            note_mismatch("in_range", 32'(rsp_if.data.in_range), 32'(want.in_range));
          if (rsp_if.data.mirroring !== want.mirroring)
            note_mismatch("mirroring", 32'(rsp_if.data.mirroring), 32'(want.mirroring));
        end
        results_checked++;
      end
    end
  end

  // result side: ready runs, random stall bursts and the long hold
  initial begin : result_sink
    int run;
    rsp_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_results) begin
        rsp_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_results = 1'b0;
      end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
        rsp_if.ready = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end else begin
        rsp_if.ready = 1'b1;
        run = $urandom_range(1, 30);
        while (run > 0 && !hold_results) begin
          @(negedge clk);
          run--;
        end
      end
    end
  end

  // one request transfer, with an optional idle burst ahead of it
  task automatic send_item(input logic [1:0] action, input logic [15:0] address,
                           input logic [7:0] data);
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    req_if.data = {action, address, data};
    req_if.valid = 1'b1;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // stop offering and wait until every result is back
  task automatic wait_idle();
    req_if.valid = 1'b0;
    while (pending_translations.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // write the bank count, then read it back while the address is still up
  task automatic write_bank_count(input logic [4:0] count);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = REG_PRG_BANK_COUNT;
    pwdata = {27'd0, count};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    bank_count_m = count;
    count_settings++;
    @(negedge clk);
    if (prdata !== {27'd0, count})
      note_mismatch("bank count readback", prdata, {27'd0, count});
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // an access somewhere interesting, mostly reads; noisy probes may be any action
  task automatic send_probe(input bit noisy);
    logic [15:0] a;
    logic [7:0] d;
    int pick;
    a = 16'($urandom);
    d = 8'($urandom);
    pick = noisy ? $urandom_range(0, 9) : $urandom_range(0, 7);
    case (pick)
      0, 1, 2: send_item(ACT_PRG_READ, {1'b1, a[14:0]}, d);
      3: send_item(ACT_PRG_READ, {3'b011, a[12:0]}, d);
      4: send_item(($urandom_range(0, 1) == 0) ? ACT_PRG_READ : ACT_PRG_WRITE,
                   {3'b011, a[12:0]}, d);
      5, 6: send_item(ACT_PATTERN, {3'b000, a[12:0]}, d);
      7: send_item(ACT_PATTERN, a, d);
      8: send_item(ACT_PRG_READ, a, d);
      default: send_item(2'($urandom_range(0, 3)), a, d);
    endcase
  endtask

  // five serial writes, value lsb first, to the register picked by sel
  task automatic serial_commit(input logic [1:0] sel, input logic [4:0] value,
                               input bit interleave);
    logic [12:0] low;
    logic [7:0] d;
    for (int i = 0; i < 5; i++) begin
      low = 13'($urandom);
      d = 8'($urandom);
      d[7] = 1'b0;
      d[0] = value[i];
      send_item(ACT_PRG_WRITE, {1'b1, sel, low}, d);
      if (interleave && $urandom_range(0, 3) == 0)
        send_probe(1'b0);
    end
  endtask

  task automatic test_directed();
    // rom window edges in the reset mode
    send_item(ACT_PRG_READ, 16'h8000, 8'h00);
    send_item(ACT_PRG_READ, 16'hBFFF, 8'hFF);
    send_item(ACT_PRG_READ, 16'hC000, 8'h00);
    send_item(ACT_PRG_READ, 16'hFFFF, 8'hFF);
    // below the rom with the ram still off
    send_item(ACT_PRG_READ, 16'h0000, 8'h00);
    send_item(ACT_PRG_READ, 16'h6000, 8'h00);
    send_item(ACT_PRG_READ, 16'h7FFF, 8'h00);
    // pattern space edges and beyond
    send_item(ACT_PATTERN, 16'h0000, 8'h00);
    send_item(ACT_PATTERN, 16'h0FFF, 8'h00);
    send_item(ACT_PATTERN, 16'h1000, 8'h00);
    send_item(ACT_PATTERN, 16'h1FFF, 8'h00);
    send_item(ACT_PATTERN, 16'h2000, 8'h00);
    send_item(ACT_PATTERN, 16'hFFFF, 8'hFF);
    // undefined action and a write below the register window
    send_item(ACT_UNUSED, 16'hFFFF, 8'hFF);
    send_item(ACT_PRG_WRITE, 16'h7FFF, 8'h01);
    // partial shift then a clearing write
    send_item(ACT_PRG_WRITE, 16'h8000, 8'h01);
    send_item(ACT_PRG_WRITE, 16'hE000, 8'h80);
    // program bank 5 with the ram enabled
    serial_commit(SEL_PRG, 5'h05, 1'b0);
    send_item(ACT_PRG_READ, 16'h6000, 8'h00);
    send_item(ACT_PRG_READ, 16'h7FFF, 8'h00);
    send_item(ACT_PRG_WRITE, 16'h6123, 8'hA5);
  endtask

  // fixed high bank under each bank count setting, extremes included
  task automatic test_bank_count();
    logic [4:0] counts[7];
    logic [15:0] a;
    counts = '{5'd0, 5'd1, 5'd2, 5'd16, 5'd17, 5'd31, 5'($urandom_range(3, 15))};
    foreach (counts[i]) begin
      wait_idle();
      write_bank_count(counts[i]);
      serial_commit(SEL_CONTROL, {1'($urandom), 2'b11, 2'($urandom)}, 1'b0);
      serial_commit(SEL_PRG, 5'($urandom), 1'b1);
      a = 16'($urandom);
      send_item(ACT_PRG_READ, {2'b11, a[13:0]}, 8'h00);
      send_item(ACT_PRG_READ, 16'hFFFF, 8'h00);
      send_item(ACT_PRG_READ, {2'b10, a[13:0]}, 8'h00);
      send_probe(1'b0);
    end
  endtask

  // mostly full register commits with random content, some noise and
  // some sequences cut short by a clearing write
  task automatic test_random_traffic();
    int pick;
    int partial;
    logic [7:0] d;
    wait_idle();
    write_bank_count(5'($urandom_range(1, 16)));
    while (items_sent < RANDOM_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
        if ($urandom_range(0, 2) == 0)
          send_item(ACT_PRG_WRITE, 16'h8000 | 16'($urandom), 8'h80 | 8'($urandom));
        serial_commit(2'($urandom), 5'($urandom), 1'b1);
        repeat ($urandom_range(2, 5)) send_probe(1'b0);
      end else if (pick < 17) begin
        repeat ($urandom_range(1, 4)) send_probe(1'b1);
      end else begin
        partial = $urandom_range(1, 4);
        repeat (partial) begin
          d = 8'($urandom);
          d[7] = 1'b0;
          send_item(ACT_PRG_WRITE, 16'h8000 | 16'($urandom), d);
        end
        send_item(ACT_PRG_WRITE, 16'h8000 | 16'($urandom), 8'h80 | 8'($urandom));
      end
    end
  endtask

  // long result hold while requests keep coming, so the input stalls
  task automatic test_backpressure();
    src_gaps = 1'b0;
    hold_results = 1'b1;
    repeat (30) send_probe(1'b0);
    while (hold_results) @(negedge clk);
    src_gaps = 1'b1;
  endtask

  // closing stretch with no idling on either side
  task automatic test_final_stream();
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    serial_commit(SEL_CONTROL, 5'($urandom), 1'b0);
    serial_commit(SEL_CHR_LOW, 5'($urandom), 1'b0);
    repeat (30) send_probe(1'b1);
  endtask

  initial begin : run_all
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_bank_count();
    test_random_traffic();
    test_backpressure();
    test_final_stream();
    wait_idle();
    repeat (10) @(negedge clk);

    $display("sent %0d accesses, checked %0d results, %0d register commits",
             items_sent, results_checked, commits_seen);
    $display("bank count written %0d times, input held off for %0d cycles",
             count_settings, input_stall_cycles);
    if (mismatch_count == 0 && pending_translations.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/sbsm_pkg.sv
hw/rtl/sbsm_if.sv
hw/rtl/serial_bank_switch_mapper.sv
sim/serial_bank_switch_mapper_test.sv
